// ===== src/lsha_pkg.sv =====
// ----------------------------------------------------------------------------
// lsha_pkg
// Shared constants for the limit switch with hysteresis and alarm block.
// ----------------------------------------------------------------------------
package lsha_pkg;

    // Fixed-point format of all values
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // Ratio dividend is pv scaled by 2^FRAC_BITS
    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    // Quotient magnitude limits for saturation
    localparam logic [NUM_W-1:0] Q_POS_MAX = NUM_W'(32'h7FFF_FFFF);
    localparam logic [NUM_W-1:0] Q_NEG_MAX = NUM_W'(32'h8000_0000);

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    // Tick counter
    localparam int               TICK_W    = 14;
    localparam logic [TICK_W-1:0] TICK_LAST = 14'd9999;

    // Config port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_LOW_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ON     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 3'd6;

    // Value modes
    localparam logic [1:0] VM_PV    = 2'd0;
    localparam logic [1:0] VM_DIFF  = 2'd1;
    localparam logic [1:0] VM_RATIO = 2'd2;

    // Alarm modes
    localparam logic [2:0] AM_A1 = 3'd0;
    localparam logic [2:0] AM_A0 = 3'd1;
    localparam logic [2:0] AM_MR = 3'd2;
    localparam logic [2:0] AM_MF = 3'd3;
    localparam logic [2:0] AM_MB = 3'd4;

endpackage

// ===== src/lsha_div.sv =====
// ----------------------------------------------------------------------------
// lsha_div
// Radix-2 restoring divider: (pv * 2^FRAC_BITS) / ref, truncated toward
// zero and saturated to signed 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsha_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [lsha_pkg::DATA_W-1:0] dividend,
    input  logic signed [lsha_pkg::DATA_W-1:0] divisor,
    output logic                              done,
    output logic signed [lsha_pkg::DATA_W-1:0] quotient
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t                     state_reg;
    logic [lsha_pkg::CNT_W-1:0]  cnt_reg;
    logic [lsha_pkg::DATA_W-1:0] rem_reg;
    logic [lsha_pkg::DATA_W-1:0] den_reg;
    logic [lsha_pkg::NUM_W-1:0]  quo_reg;
    logic                        neg_reg;

    logic [lsha_pkg::DATA_W-1:0] pv_mag;
    logic [lsha_pkg::DATA_W-1:0] ref_mag;
    logic [lsha_pkg::DATA_W:0]   trial;
    logic [lsha_pkg::DATA_W+1:0] diff;
    logic                        borrow;

    assign pv_mag  = dividend[lsha_pkg::DATA_W-1] ? (~dividend + 32'd1) : dividend;
    assign ref_mag = divisor[lsha_pkg::DATA_W-1]  ? (~divisor + 32'd1)  : divisor;

    assign trial  = {rem_reg, quo_reg[lsha_pkg::NUM_W-1]};
    assign diff   = {1'b0, trial} - {2'b00, den_reg};
    assign borrow = diff[lsha_pkg::DATA_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= D_RUN;
                        cnt_reg   <= lsha_pkg::CNT_W'(lsha_pkg::NUM_W);
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == lsha_pkg::CNT_W'(1))
                        state_reg <= D_FIN;
                end
                D_FIN:
                    state_reg <= D_IDLE;
                default:
                    state_reg <= D_IDLE;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            rem_reg <= '0;
            den_reg <= ref_mag;
            quo_reg <= lsha_pkg::NUM_W'(pv_mag) << lsha_pkg::FRAC_BITS;
            neg_reg <= dividend[lsha_pkg::DATA_W-1] ^ divisor[lsha_pkg::DATA_W-1];
        end
        else if (state_reg == D_RUN)
        begin
            rem_reg <= borrow ? trial[lsha_pkg::DATA_W-1:0] : diff[lsha_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[lsha_pkg::NUM_W-2:0], ~borrow};
        end
    end

    assign done = (state_reg == D_FIN);

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > lsha_pkg::Q_NEG_MAX)
                quotient = lsha_pkg::S32_MIN;
            else
                quotient = ~quo_reg[lsha_pkg::DATA_W-1:0] + 32'd1;
        end
        else
        begin
            if (quo_reg > lsha_pkg::Q_POS_MAX)
                quotient = lsha_pkg::S32_MAX;
            else
                quotient = quo_reg[lsha_pkg::DATA_W-1:0];
        end
    end

endmodule

// ===== src/limit_switch_hysteresis_alarm.sv =====
// ----------------------------------------------------------------------------
// limit_switch_hysteresis_alarm
// Limit switch with hysteresis and alarm/message flag on a modified process
// value (pv, pv - ref or pv / ref), signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carries one request per tick (enable,
//   process_value, reference_value, limit_value). in_stall is high while a
//   request is in work; one request is handled at a time.
//   Output channel: out_valid / out_stall returns one result per request.
//   The result sits in an output register, so the next request is taken
//   while the previous result still waits on a stalled receiver; a finished
//   request then waits until that register is free.
//   A request passes through the calc, eval and done states before out_valid
//   rises; in ratio mode the divider runs between calc and eval, producing
//   one quotient bit per cycle over a 48-bit dividend before its finish
//   state. in_stall falls in the same cycle that out_valid rises, so the
//   next request can be taken then.
//   Configuration is written through cfg_write / cfg_index / cfg_data while
//   the block is idle; writes to unused indexes are ignored.
//   Reset: config registers go to their defaults, switch and alarm state,
//   held value and tick counter clear, no result is pending.
// ----------------------------------------------------------------------------
module limit_switch_hysteresis_alarm (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [lsha_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lsha_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  enable,
    input  logic signed [lsha_pkg::DATA_W-1:0]    process_value,
    input  logic signed [lsha_pkg::DATA_W-1:0]    reference_value,
    input  logic signed [lsha_pkg::DATA_W-1:0]    limit_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  enable_out,
    output logic signed [lsha_pkg::DATA_W-1:0]    modified_value,
    output logic                                  switch_out,
    output logic                                  alarm_flag,
    output logic [lsha_pkg::TICK_W-1:0]           tick_count
);

    typedef enum logic [2:0] {S_IDLE, S_CALC, S_DIV, S_EVAL, S_DONE} state_t;

    // configuration
    logic [1:0]                         value_mode_reg;
    logic                               is_low_limit_reg;
    logic                               alarm_on_reg;
    logic [2:0]                         alarm_mode_reg;
    logic signed [lsha_pkg::DATA_W-1:0] limit_min_reg;
    logic signed [lsha_pkg::DATA_W-1:0] limit_max_reg;
    logic [lsha_pkg::DATA_W-2:0]        hysteresis_reg;

    // sequencer and block state
    state_t                             state_reg,         state_next;
    logic                               en_reg,            en_next;
    logic signed [lsha_pkg::DATA_W-1:0] pv_reg,            pv_next;
    logic signed [lsha_pkg::DATA_W-1:0] ref_reg,           ref_next;
    logic signed [lsha_pkg::DATA_W-1:0] lim_reg,           lim_next;
    logic                               en_out_pend_reg,   en_out_pend_next;
    logic signed [lsha_pkg::DATA_W-1:0] modified_reg,      modified_next;
    logic                               switch_prev_reg,   switch_prev_next;
    logic                               alarm_reg,         alarm_next;
    logic [lsha_pkg::TICK_W-1:0]        tick_reg,          tick_next;

    // output register
    logic                               out_valid_reg,     out_valid_next;
    logic                               enable_out_reg,    enable_out_next;
    logic signed [lsha_pkg::DATA_W-1:0] modified_out_reg,  modified_out_next;
    logic                               switch_out_reg,    switch_out_next;
    logic                               alarm_out_reg,     alarm_out_next;
    logic [lsha_pkg::TICK_W-1:0]        tick_out_reg,      tick_out_next;

    logic                               div_start;
    logic                               div_done;
    logic signed [lsha_pkg::DATA_W-1:0] div_quot;

    logic signed [lsha_pkg::DATA_W:0]   diff_wide;
    logic signed [lsha_pkg::DATA_W-1:0] diff_sat;
    logic signed [lsha_pkg::DATA_W-1:0] lim_clamped;
    logic signed [lsha_pkg::DATA_W+1:0] m_wide;
    logic signed [lsha_pkg::DATA_W+1:0] lim_wide;
    logic signed [lsha_pkg::DATA_W+1:0] hyst_wide;
    logic                               qs;
    logic                               alarm_val;
    logic                               alarm_ok;

    lsha_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pv_reg),
        .divisor  (ref_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_mode_reg   <= lsha_pkg::VM_PV;
            is_low_limit_reg <= 1'b0;
            alarm_on_reg     <= 1'b0;
            alarm_mode_reg   <= lsha_pkg::AM_A1;
            limit_min_reg    <= lsha_pkg::S32_MIN;
            limit_max_reg    <= lsha_pkg::S32_MAX;
            hysteresis_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lsha_pkg::CFG_VALUE_MODE:   value_mode_reg   <= cfg_data[1:0];
                lsha_pkg::CFG_IS_LOW_LIMIT: is_low_limit_reg <= cfg_data[0];
                lsha_pkg::CFG_ALARM_ON:     alarm_on_reg     <= cfg_data[0];
                lsha_pkg::CFG_ALARM_MODE:   alarm_mode_reg   <= cfg_data[2:0];
                lsha_pkg::CFG_LIMIT_MIN:    limit_min_reg    <= cfg_data;
                lsha_pkg::CFG_LIMIT_MAX:    limit_max_reg    <= cfg_data;
                lsha_pkg::CFG_HYSTERESIS:   hysteresis_reg   <= cfg_data[lsha_pkg::DATA_W-2:0];
                default: ;
            endcase
        end
    end

    // difference with saturation
    assign diff_wide = {pv_reg[lsha_pkg::DATA_W-1], pv_reg}
                     - {ref_reg[lsha_pkg::DATA_W-1], ref_reg};
    always_comb
    begin
        if (diff_wide[lsha_pkg::DATA_W] != diff_wide[lsha_pkg::DATA_W-1])
            diff_sat = diff_wide[lsha_pkg::DATA_W] ? lsha_pkg::S32_MIN : lsha_pkg::S32_MAX;
        else
            diff_sat = diff_wide[lsha_pkg::DATA_W-1:0];
    end

    // with an inverted window, values below min clamp to min, all others to max
    always_comb
    begin
        if (lim_reg < limit_min_reg)
            lim_clamped = limit_min_reg;
        else if (lim_reg > limit_max_reg)
            lim_clamped = limit_max_reg;
        else
            lim_clamped = lim_reg;
    end

    // switch with hysteresis, exact 34-bit thresholds
    assign m_wide    = {{2{modified_reg[lsha_pkg::DATA_W-1]}}, modified_reg};
    assign lim_wide  = {{2{lim_reg[lsha_pkg::DATA_W-1]}}, lim_reg};
    assign hyst_wide = {3'b000, hysteresis_reg};

    always_comb
    begin
        qs = switch_prev_reg;
        if (is_low_limit_reg)
        begin
            if (!switch_prev_reg && m_wide < lim_wide)
                qs = 1'b1;
            else if (switch_prev_reg && m_wide > lim_wide + hyst_wide)
                qs = 1'b0;
        end
        else
        begin
            if (!switch_prev_reg && m_wide > lim_wide)
                qs = 1'b1;
            else if (switch_prev_reg && m_wide < lim_wide - hyst_wide)
                qs = 1'b0;
        end
    end

    always_comb
    begin
        alarm_ok = 1'b1;
        case (alarm_mode_reg)
            lsha_pkg::AM_A1: alarm_val = qs;
            lsha_pkg::AM_A0: alarm_val = ~qs;
            lsha_pkg::AM_MR: alarm_val = qs & ~switch_prev_reg;
            lsha_pkg::AM_MF: alarm_val = ~qs & switch_prev_reg;
            lsha_pkg::AM_MB: alarm_val = qs ^ switch_prev_reg;
            default:
            begin
                alarm_val = 1'b0;
                alarm_ok  = 1'b0;
            end
        endcase
    end

    assign div_start = (state_reg == S_CALC) && en_reg
                    && (value_mode_reg == lsha_pkg::VM_RATIO) && (ref_reg != '0);

    always_comb
    begin
        state_next        = state_reg;
        en_next           = en_reg;
        pv_next           = pv_reg;
        ref_next          = ref_reg;
        lim_next          = lim_reg;
        en_out_pend_next  = en_out_pend_reg;
        modified_next     = modified_reg;
        switch_prev_next  = switch_prev_reg;
        alarm_next        = alarm_reg;
        tick_next         = tick_reg;
        out_valid_next    = out_valid_reg;
        enable_out_next   = enable_out_reg;
        modified_out_next = modified_out_reg;
        switch_out_next   = switch_out_reg;
        alarm_out_next    = alarm_out_reg;
        tick_out_next     = tick_out_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    en_next    = enable;
                    pv_next    = process_value;
                    ref_next   = reference_value;
                    lim_next   = limit_value;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                lim_next         = lim_clamped;
                en_out_pend_next = en_reg;
                state_next       = S_EVAL;
                if (en_reg)
                begin
                    case (value_mode_reg)
                        lsha_pkg::VM_PV:   modified_next = pv_reg;
                        lsha_pkg::VM_DIFF: modified_next = diff_sat;
                        lsha_pkg::VM_RATIO:
                        begin
                            if (ref_reg == '0)
                            begin
                                modified_next    = '0;
                                en_out_pend_next = 1'b0;
                            end
                            else
                                state_next = S_DIV;
                        end
                        default: en_out_pend_next = 1'b0;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    modified_next = div_quot;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (en_reg)
                begin
                    switch_prev_next = qs;
                    if (alarm_on_reg)
                    begin
                        alarm_next = alarm_val;
                        if (!alarm_ok)
                            en_out_pend_next = 1'b0;
                    end
                end
                tick_next  = (tick_reg == lsha_pkg::TICK_LAST) ? '0 : tick_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    enable_out_next   = en_out_pend_reg;
                    modified_out_next = modified_reg;
                    switch_out_next   = switch_prev_reg;
                    alarm_out_next    = alarm_reg;
                    tick_out_next     = tick_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            modified_reg    <= '0;
            switch_prev_reg <= 1'b0;
            alarm_reg       <= 1'b0;
            tick_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            modified_reg    <= modified_next;
            switch_prev_reg <= switch_prev_next;
            alarm_reg       <= alarm_next;
            tick_reg        <= tick_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        en_reg           <= en_next;
        pv_reg           <= pv_next;
        ref_reg          <= ref_next;
        lim_reg          <= lim_next;
        en_out_pend_reg  <= en_out_pend_next;
        enable_out_reg   <= enable_out_next;
        modified_out_reg <= modified_out_next;
        switch_out_reg   <= switch_out_next;
        alarm_out_reg    <= alarm_out_next;
        tick_out_reg     <= tick_out_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign enable_out     = enable_out_reg;
    assign modified_value = modified_out_reg;
    assign switch_out     = switch_out_reg;
    assign alarm_flag     = alarm_out_reg;
    assign tick_count     = tick_out_reg;

endmodule
